FILE: hw/rtl/olu_pkg.sv
// Shared types and codes for the ordered array list unit.
`timescale 1ns / 1ps

package olu_pkg;

    // Request command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // Result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Fixed widths of the result fields
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_FLUSH,
        ST_PUT_KEY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

FILE: hw/rtl/olu_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module olu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/olu_seq.sv
// Sequencer: walks the entry store for find, insert shift and remove shift.
`timescale 1ns / 1ps

module olu_seq #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // request side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_command,
    input  logic [3:0]                  in_position,
    input  logic [KEY_BITS-1:0]         in_key,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output olu_pkg::result_t            res,
    // entry store
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [KEY_BITS-1:0]         rd_data,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [KEY_BITS-1:0]         wr_data
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > 4) ? CW : 4;
    localparam int IXW = (AW > olu_pkg::INDEX_W) ? AW : olu_pkg::INDEX_W;
    localparam int OCW = (CW > olu_pkg::COUNT_W) ? CW : olu_pkg::COUNT_W;

    olu_pkg::state_t state_reg, state_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       lim_reg, lim_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [1:0]          op_reg, op_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic                status_reg, status_next;
    logic [AW-1:0]       index_reg, index_next;

    logic          in_fire;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic          ins_ok;
    logic          rem_ok;
    logic          found;
    logic          more;
    logic          rd_issue;
    logic [CW-1:0] rd_ptr;
    logic [IXW-1:0] index_ext;
    logic [OCW-1:0] count_ext;

    assign in_fire = in_valid && in_ready;
    assign pos_w   = PW'(in_position);
    assign cnt_w   = PW'(count_reg);
    assign ins_ok  = (count_reg < CW'(CAPACITY)) && (pos_w <= cnt_w);
    assign rem_ok  = pos_w < cnt_w;
    assign found   = (state_reg == olu_pkg::ST_SCAN) && pend_reg && (rd_data == key_reg);
    assign more    = ptr_reg < lim_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olu_pkg::ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_command)
                        olu_pkg::CMD_INSERT: begin
                            if (!ins_ok) begin
                                state_next = olu_pkg::ST_DONE;
                            end else if (pos_w == cnt_w) begin
                                state_next = olu_pkg::ST_PUT_KEY;
                            end else begin
                                state_next = olu_pkg::ST_SHIFT_UP;
                            end
                        end
                        olu_pkg::CMD_FIND: begin
                            state_next = olu_pkg::ST_SCAN;
                        end
                        olu_pkg::CMD_REMOVE: begin
                            if (!rem_ok || (pos_w == cnt_w - PW'(1))) begin
                                state_next = olu_pkg::ST_DONE;
                            end else begin
                                state_next = olu_pkg::ST_SHIFT_DN;
                            end
                        end
                        default: begin
                            state_next = olu_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            olu_pkg::ST_SCAN: begin
                if (found || !more) begin
                    state_next = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::ST_SHIFT_UP: begin
                if (ptr_reg - CW'(1) == pos_reg) begin
                    state_next = olu_pkg::ST_FLUSH;
                end
            end
            olu_pkg::ST_SHIFT_DN: begin
                if (ptr_reg + CW'(1) == lim_reg - CW'(1)) begin
                    state_next = olu_pkg::ST_FLUSH;
                end
            end
            olu_pkg::ST_FLUSH: begin
                if (op_reg == olu_pkg::CMD_INSERT) begin
                    state_next = olu_pkg::ST_PUT_KEY;
                end else begin
                    state_next = olu_pkg::ST_DONE;
                end
            end
            olu_pkg::ST_PUT_KEY: begin
                state_next = olu_pkg::ST_DONE;
            end
            olu_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = olu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = olu_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshakes and memory ports
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_issue  = 1'b0;
        rd_ptr    = ptr_reg;
        wr_en     = pend_reg && (op_reg != olu_pkg::CMD_FIND);
        wr_addr   = pend_addr_reg;
        wr_data   = rd_data;
        unique case (state_reg)
            olu_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            olu_pkg::ST_SCAN: begin
                rd_issue = !found && more;
            end
            olu_pkg::ST_SHIFT_UP: begin
                rd_issue = 1'b1;
                rd_ptr   = ptr_reg - CW'(1);
            end
            olu_pkg::ST_SHIFT_DN: begin
                rd_issue = 1'b1;
                rd_ptr   = ptr_reg + CW'(1);
            end
            olu_pkg::ST_FLUSH: begin
                rd_issue = 1'b0;
            end
            olu_pkg::ST_PUT_KEY: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[AW-1:0];
                wr_data = key_reg;
            end
            olu_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign rd_addr = rd_ptr[AW-1:0];

    // Datapath next values
    always_comb begin
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        lim_next       = lim_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        index_next     = index_reg;
        pend_next      = rd_issue;
        pend_addr_next = pend_addr_reg;

        if (in_fire) begin
            op_next     = in_command;
            key_next    = in_key;
            pos_next    = CW'(in_position);
            lim_next    = count_reg;
            index_next  = '0;
            status_next = olu_pkg::STATUS_FAIL;
            unique case (in_command)
                olu_pkg::CMD_INSERT: begin
                    if (ins_ok) begin
                        status_next = olu_pkg::STATUS_OK;
                        count_next  = count_reg + CW'(1);
                        ptr_next    = count_reg;
                    end
                end
                olu_pkg::CMD_FIND: begin
                    ptr_next = '0;
                end
                olu_pkg::CMD_REMOVE: begin
                    if (rem_ok) begin
                        status_next = olu_pkg::STATUS_OK;
                        count_next  = count_reg - CW'(1);
                        ptr_next    = CW'(in_position);
                    end
                end
                default: begin
                    ptr_next = ptr_reg;
                end
            endcase
        end

        if (state_reg == olu_pkg::ST_SCAN && found) begin
            status_next = olu_pkg::STATUS_OK;
            index_next  = pend_addr_reg;
        end

        if (rd_issue) begin
            unique case (state_reg)
                olu_pkg::ST_SHIFT_UP: begin
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg - CW'(1);
                end
                olu_pkg::ST_SHIFT_DN: begin
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + CW'(1);
                end
                default: begin
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + CW'(1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olu_pkg::ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        lim_reg       <= lim_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        op_reg        <= op_next;
        pend_addr_reg <= pend_addr_next;
        status_reg    <= status_next;
        index_reg     <= index_next;
    end

    assign index_ext  = IXW'(index_reg);
    assign count_ext  = OCW'(count_reg);
    assign res.status = status_reg;
    assign res.index  = index_ext[olu_pkg::INDEX_W-1:0];
    assign res.count  = count_ext[olu_pkg::COUNT_W-1:0];

    // The list never grows past its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A shift never reads the entry that is being written in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_issue) |-> (wr_addr != rd_addr))
        else $error("read and write collide on one entry");

    // The store is written only while a shift or key write is under way.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == olu_pkg::ST_SHIFT_UP || state_reg == olu_pkg::ST_SHIFT_DN ||
                   state_reg == olu_pkg::ST_FLUSH || state_reg == olu_pkg::ST_PUT_KEY))
        else $error("store written outside a shift");

    // An accepted insert that fits grows the list by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_command == olu_pkg::CMD_INSERT && ins_ok)
            |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    // A result waiting for the output stage holds its fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res)))
        else $error("pending result changed");

endmodule

FILE: hw/rtl/ordered_array_list_unit.sv
// Top level of the ordered array list unit: sequencer, entry store and output register.
`timescale 1ns / 1ps
//
// Ordered array list of up to CAPACITY keys of KEY_BITS bits each.
// Input channel (s_valid/s_ready): one request of command, position and key.
//   Insert places the key at a position from 0 to count and shifts later entries up;
//   find returns the first index holding the key; remove deletes the entry at a
//   position and shifts later entries down. Bad positions, a full list and the
//   unused command give status 1 and leave the list alone.
// Output channel (m_valid/m_ready): one result per request with status, index, count.
// The entry store has a single read and a single write port, so
// every shift moves one entry per cycle, read one cycle and written back the next.
// One request is worked on at a time; s_ready rises at the edge that moves the result
// into the output register, so a new request is taken only after the last one's result left.
// While the receiver stalls, one more request can finish and wait in the sequencer.
// Reset clears the count and the handshake state; entry contents are not cleared,
// since no entry at or above the count is ever read.
//

module ordered_array_list_unit #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_position,
    input  logic [63:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [3:0]  m_index,
    output logic [4:0]  m_count
);

    localparam int AW = $clog2(CAPACITY);

    logic                res_valid;
    logic                res_ready;
    olu_pkg::result_t    res;
    logic [AW-1:0]       rd_addr;
    logic [KEY_BITS-1:0] rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    logic             m_valid_reg;
    olu_pkg::result_t m_res_reg;

    // Drop key bits above KEY_BITS before store and compare.
    olu_seq #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_command  (s_command),
        .in_position (s_position),
        .in_key      (s_key[KEY_BITS-1:0]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    olu_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_BITS)
    ) u_ram (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: take a new result when empty or when the current one leaves.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Hold the payload while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_res_reg.status;
    assign m_index  = m_res_reg.index;
    assign m_count  = m_res_reg.count;

endmodule
